/* sv/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define GCNS_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define GCNS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/gcns_pkg.sv */
// ----------------------------------------------------------------------------
// gcns_pkg
// Types, sizes and codes shared by the grid cell neighbor search block.
// ----------------------------------------------------------------------------
package gcns_pkg;

   localparam int MAX_PARTICLES = 1024;
   localparam int MAX_NEIGHBORS = 64;
   localparam int IDX_W         = $clog2(MAX_PARTICLES);
   localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
   localparam int NB_W          = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int NBC_W         = $clog2(MAX_NEIGHBORS + 1);
   localparam int POS_W         = 32;
   localparam int CELL_W        = POS_W + 1;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_FULL       = 2'd1;
   localparam logic [1:0] STATUS_NOT_LOADED = 2'd2;

   localparam logic [31:0] CELL_SIZE_RESET = 32'd65536;

   typedef struct packed {
      logic [1:0]              kind;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic                    is_boundary;
      logic [IDX_W-1:0]        query_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] neighbor_index;
      logic             none_found;
      logic             is_last;
      logic             overflow;
      logic [1:0]       status;
   } rsp_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_LOAD,
      EMIT_FULL,
      EMIT_CLEAR,
      EMIT_NOT_LOADED,
      EMIT_EMPTY,
      EMIT_LIST
   } emit_type;

   typedef struct packed {
      logic       latch;
      emit_type   emit;
      logic       div_start;
      logic [1:0] div_sel;
      logic       mem_write;
      logic       count_clear;
      logic       rd_en;
      logic       rd_query;
      logic       cap_query;
      logic       scan_init;
      logic       off_next;
      logic       eval;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       acc_load;
      logic       acc_add;
      logic       judge;
      logic       play_init;
      logic       play_rd;
      logic       play_next;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       full;
      logic       q_bad;
      logic       q_boundary;
      logic       div_done;
      logic       cand_hit;
      logic       j_end;
      logic       off_end;
      logic       list_empty;
      logic       play_last;
   } stat_type;

endpackage

/* sv/gcns_div.sv */
// ----------------------------------------------------------------------------
// gcns_div
// Bit-serial floor division of a signed position by an unsigned cell size.
// ----------------------------------------------------------------------------
module gcns_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [gcns_pkg::POS_W-1:0]   dividend,
   input  logic [31:0]                         divisor,
   output logic                                done,
   output logic signed [gcns_pkg::CELL_W-1:0]  quotient
);
   import gcns_pkg::*;

   logic                     running_ff;
   logic                     fin_ff;
   logic                     done_ff;
   logic [4:0]               cnt_ff;
   logic                     neg_ff;
   logic [31:0]              dv_ff;
   logic [31:0]              quo_ff;
   logic [31:0]              rem_ff;
   logic signed [CELL_W-1:0] q_ff;

   logic [32:0]       shifted;
   logic              ge;
   logic [31:0]       rem_in;
   logic [CELL_W-1:0] sum;
   logic [31:0]       mag;

   assign mag     = dividend[POS_W-1] ? 32'(-dividend) : 32'(dividend);
   assign shifted = {rem_ff, quo_ff[31]};
   assign ge      = shifted >= {1'b0, dv_ff};
   assign rem_in  = ge ? 32'(shifted - {1'b0, dv_ff}) : shifted[31:0];
   assign sum     = {1'b0, quo_ff} + CELL_W'(rem_ff != 32'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         fin_ff     <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         done_ff <= fin_ff;
         if (start) begin
            running_ff <= 1'b1;
            cnt_ff     <= 5'd0;
            quo_ff     <= mag;
            rem_ff     <= 32'd0;
            dv_ff      <= divisor;
            neg_ff     <= dividend[POS_W-1];
         end else if (running_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[30:0], ge};
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               running_ff <= 1'b0;
               fin_ff     <= 1'b1;
            end
         end
         if (fin_ff) begin
            fin_ff  <= 1'b0;
            // round toward minus infinity for negative positions
            q_ff    <= neg_ff ? $signed(-sum) : $signed({1'b0, quo_ff});
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

/* sv/gcns_dp.sv */
// ----------------------------------------------------------------------------
// gcns_dp
// Particle store, distance unit, neighbor list buffer and result register.
// ----------------------------------------------------------------------------
module gcns_dp (
   input  logic              clock,
   input  logic              reset,
   input  gcns_pkg::req_type req_data,
   input  logic              csr_valid,
   input  logic [31:0]       csr_data,
   output logic              csr_ready,
   input  gcns_pkg::cmd_type cmd,
   output gcns_pkg::stat_type stat,
   output logic              rsp_valid,
   output gcns_pkg::rsp_type rsp_data
);
   import gcns_pkg::*;

   typedef struct packed {
      logic signed [POS_W-1:0]  x;
      logic signed [POS_W-1:0]  y;
      logic signed [POS_W-1:0]  z;
      logic                     boundary;
      logic signed [CELL_W-1:0] cx;
      logic signed [CELL_W-1:0] cy;
      logic signed [CELL_W-1:0] cz;
   } rec_type;

   function automatic logic [31:0] abs_diff(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
      logic [POS_W:0] d;
      d = {a[POS_W-1], a} - {b[POS_W-1], b};
      return d[POS_W] ? 32'(-d) : d[31:0];
   endfunction

   function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   function automatic logic cell_eq(logic [CELL_W-1:0] qc, logic [1:0] d,
                                    logic [CELL_W-1:0] rc);
      logic [CELL_W:0] t;
      t = {qc[CELL_W-1], qc} + {{(CELL_W-1){1'b0}}, d} - (CELL_W+1)'(1);
      return t == {rc[CELL_W-1], rc};
   endfunction

   logic [31:0]        cell_size_ff;
   logic [31:0]        eff_cs;
   logic [63:0]        r2_ff;
   req_type            req_ff;
   logic               div_done;
   logic signed [CELL_W-1:0] div_q;
   logic signed [POS_W-1:0]  div_a;
   logic signed [CELL_W-1:0] cell_ff [3];

   rec_type            mem [MAX_PARTICLES];
   rec_type            rd_ff;
   rec_type            qrec_ff;
   rec_type            wr_rec;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   j_ff;
   logic [1:0]         d_ff [3];

   logic [IDX_W-1:0]   cand_ff;
   logic [31:0]        mag_ff [3];
   logic [63:0]        prod_ff;
   logic [63:0]        acc_ff;
   logic               in_radius;

   logic [IDX_W-1:0]   nbuf [MAX_NEIGHBORS];
   logic [IDX_W-1:0]   nb_rd_ff;
   logic [NBC_W-1:0]   n_ff;
   logic [NBC_W-1:0]   k_ff;
   logic               ovf_ff;
   logic               nb_write;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   assign csr_ready = 1'b1;
   assign eff_cs    = (cell_size_ff == 32'd0) ? 32'd1 : cell_size_ff;

   always_comb begin
      case (cmd.div_sel)
         2'd0:    div_a = req_ff.pos_x;
         2'd1:    div_a = req_ff.pos_y;
         default: div_a = req_ff.pos_z;
      endcase
   end

   gcns_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (eff_cs),
      .done     (div_done),
      .quotient (div_q)
   );

   // cell size register and its square
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= CELL_SIZE_RESET;
      end else if (csr_valid) begin
         cell_size_ff <= csr_data;
      end
      r2_ff <= eff_cs * eff_cs;
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_data;
      end
      if (div_done) begin
         cell_ff[cmd.div_sel] <= div_q;
      end
   end

   assign wr_rec  = '{x: req_ff.pos_x, y: req_ff.pos_y, z: req_ff.pos_z,
                      boundary: req_ff.is_boundary,
                      cx: cell_ff[0], cy: cell_ff[1], cz: cell_ff[2]};
   assign rd_addr = cmd.rd_query ? req_ff.query_index : j_ff[IDX_W-1:0];

   // particle store
   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         mem[count_ff[IDX_W-1:0]] <= wr_rec;
      end
      if (cmd.rd_en) begin
         rd_ff     <= mem[rd_addr];
         rd_idx_ff <= rd_addr;
      end
      if (cmd.cap_query) begin
         qrec_ff <= rd_ff;
      end
   end

   // fill count, scan index and cell offsets
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         j_ff     <= '0;
         d_ff     <= '{2'd0, 2'd0, 2'd0};
      end else begin
         if (cmd.count_clear) begin
            count_ff <= '0;
         end else if (cmd.mem_write) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.scan_init) begin
            j_ff <= '0;
            d_ff <= '{2'd0, 2'd0, 2'd0};
         end else if (cmd.off_next) begin
            j_ff <= '0;
            if (d_ff[2] != 2'd2) begin
               d_ff[2] <= d_ff[2] + 2'd1;
            end else begin
               d_ff[2] <= 2'd0;
               if (d_ff[1] != 2'd2) begin
                  d_ff[1] <= d_ff[1] + 2'd1;
               end else begin
                  d_ff[1] <= 2'd0;
                  d_ff[0] <= d_ff[0] + 2'd1;
               end
            end
         end else if (cmd.rd_en && !cmd.rd_query) begin
            j_ff <= j_ff + CNT_W'(1);
         end
      end
   end

   // distance unit: one squarer shared over the three axes
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         cand_ff   <= rd_idx_ff;
         mag_ff[0] <= abs_diff(rd_ff.x, qrec_ff.x);
         mag_ff[1] <= abs_diff(rd_ff.y, qrec_ff.y);
         mag_ff[2] <= abs_diff(rd_ff.z, qrec_ff.z);
      end
      if (cmd.mul_en) begin
         prod_ff <= mag_ff[cmd.mul_sel] * mag_ff[cmd.mul_sel];
      end
      if (cmd.acc_load) begin
         acc_ff <= prod_ff;
      end else if (cmd.acc_add) begin
         acc_ff <= sat_add(acc_ff, prod_ff);
      end
   end

   assign in_radius = sat_add(acc_ff, prod_ff) <= r2_ff;
   assign nb_write  = cmd.judge && in_radius && (n_ff != NBC_W'(MAX_NEIGHBORS));

   // neighbor list buffer
   always_ff @(posedge clock) begin
      if (nb_write) begin
         nbuf[n_ff[NB_W-1:0]] <= cand_ff;
      end
      if (cmd.play_rd) begin
         nb_rd_ff <= nbuf[k_ff[NB_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff   <= '0;
         k_ff   <= '0;
         ovf_ff <= 1'b0;
      end else begin
         if (cmd.scan_init) begin
            n_ff   <= '0;
            ovf_ff <= 1'b0;
         end else if (nb_write) begin
            n_ff <= n_ff + NBC_W'(1);
         end else if (cmd.judge && in_radius) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.play_init) begin
            k_ff <= '0;
         end else if (cmd.play_next) begin
            k_ff <= k_ff + NBC_W'(1);
         end
      end
   end

   always_comb begin
      rsp_in = '{neighbor_index: '0, none_found: 1'b1, is_last: 1'b1,
                 overflow: 1'b0, status: STATUS_OK};
      unique case (cmd.emit)
         EMIT_LOAD:       rsp_in.neighbor_index = count_ff[IDX_W-1:0];
         EMIT_FULL:       rsp_in.status = STATUS_FULL;
         EMIT_NOT_LOADED: rsp_in.status = STATUS_NOT_LOADED;
         EMIT_LIST: begin
            rsp_in.neighbor_index = nb_rd_ff;
            rsp_in.none_found     = 1'b0;
            rsp_in.is_last        = stat.play_last;
            rsp_in.overflow       = ovf_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit != EMIT_NONE;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign stat.kind       = req_ff.kind;
   assign stat.full       = count_ff == CNT_W'(MAX_PARTICLES);
   assign stat.q_bad      = CNT_W'(req_ff.query_index) >= count_ff;
   assign stat.q_boundary = rd_ff.boundary;
   assign stat.div_done   = div_done;
   assign stat.cand_hit   = (rd_idx_ff != req_ff.query_index)
                            && cell_eq(qrec_ff.cx, d_ff[0], rd_ff.cx)
                            && cell_eq(qrec_ff.cy, d_ff[1], rd_ff.cy)
                            && cell_eq(qrec_ff.cz, d_ff[2], rd_ff.cz);
   assign stat.j_end      = j_ff == count_ff;
   assign stat.off_end    = (d_ff[0] == 2'd2) && (d_ff[1] == 2'd2) && (d_ff[2] == 2'd2);
   assign stat.list_empty = n_ff == '0;
   assign stat.play_last  = (k_ff + NBC_W'(1)) == n_ff;

endmodule

/* sv/gcns_ctrl.sv */
// ----------------------------------------------------------------------------
// gcns_ctrl
// Sequencer for load, clear and query items.
// ----------------------------------------------------------------------------
module gcns_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  gcns_pkg::stat_type stat,
   output gcns_pkg::cmd_type  cmd
);
   import gcns_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_DIVGO, S_DIV, S_WRITE, S_QRD, S_QCAP,
      S_SREAD, S_SEVAL, S_SMX, S_SMY, S_SMZ, S_SJUDGE, S_PLAY, S_PRD, S_PEMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic       busy_ff;

   always_comb begin
      state_in    = state_ff;
      axis_in     = axis_ff;
      cmd         = '0;
      cmd.emit    = EMIT_NONE;
      cmd.div_sel = axis_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_IDLE;
            unique case (stat.kind)
               KIND_LOAD: begin
                  if (stat.full) begin
                     cmd.emit = EMIT_FULL;
                  end else begin
                     axis_in  = 2'd0;
                     state_in = S_DIVGO;
                  end
               end
               KIND_CLEAR: begin
                  cmd.count_clear = 1'b1;
                  cmd.emit        = EMIT_CLEAR;
               end
               KIND_QUERY: begin
                  if (stat.q_bad) begin
                     cmd.emit = EMIT_NOT_LOADED;
                  end else begin
                     state_in = S_QRD;
                  end
               end
               default: ;
            endcase
         end
         S_DIVGO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (stat.div_done) begin
               axis_in  = axis_ff + 2'd1;
               state_in = (axis_ff == 2'd2) ? S_WRITE : S_DIVGO;
            end
         end
         S_WRITE: begin
            cmd.mem_write = 1'b1;
            cmd.emit      = EMIT_LOAD;
            state_in      = S_IDLE;
         end
         S_QRD: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_query = 1'b1;
            state_in     = S_QCAP;
         end
         S_QCAP: begin
            if (stat.q_boundary) begin
               cmd.emit = EMIT_EMPTY;
               state_in = S_IDLE;
            end else begin
               cmd.cap_query = 1'b1;
               cmd.scan_init = 1'b1;
               state_in      = S_SREAD;
            end
         end
         S_SREAD: begin
            if (stat.j_end) begin
               if (stat.off_end) begin
                  state_in = S_PLAY;
               end else begin
                  cmd.off_next = 1'b1;
               end
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_SEVAL;
            end
         end
         S_SEVAL: begin
            cmd.eval = 1'b1;
            state_in = stat.cand_hit ? S_SMX : S_SREAD;
         end
         S_SMX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = 2'd0;
            state_in    = S_SMY;
         end
         S_SMY: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = 2'd1;
            cmd.acc_load = 1'b1;
            state_in     = S_SMZ;
         end
         S_SMZ: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = 2'd2;
            cmd.acc_add = 1'b1;
            state_in    = S_SJUDGE;
         end
         S_SJUDGE: begin
            cmd.judge = 1'b1;
            state_in  = S_SREAD;
         end
         S_PLAY: begin
            if (stat.list_empty) begin
               cmd.emit = EMIT_EMPTY;
               state_in = S_IDLE;
            end else begin
               cmd.play_init = 1'b1;
               state_in      = S_PRD;
            end
         end
         S_PRD: begin
            cmd.play_rd = 1'b1;
            state_in    = S_PEMIT;
         end
         S_PEMIT: begin
            cmd.emit      = EMIT_LIST;
            cmd.play_next = 1'b1;
            state_in      = stat.play_last ? S_IDLE : S_PRD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= 2'd0;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         busy_ff  <= state_in != S_IDLE;
      end
   end

   assign busy = busy_ff;

endmodule

/* sv/grid_cell_neighbor_search.sv */
// ----------------------------------------------------------------------------
// grid_cell_neighbor_search
// Uniform grid cell list neighbor search over a store of particles.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high while
// the item is worked on and falls in the cycle that carries its last result.
// Results appear on rsp_data for one cycle each with rsp_valid, and the
// receiver cannot stall them. A load is paced by the bit-serial divider that
// finds the cell on each of the three axes in turn. A query makes a pass over
// the particle store through its single read port for every one of the 27
// neighbor cells, and a candidate in a matching cell also goes through the
// shared squaring multiplier. The store needs no clearing pass after reset;
// the fill count marks which entries hold particles.
// ----------------------------------------------------------------------------
module grid_cell_neighbor_search (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gcns_pkg::req_type req_data,
   output logic              rsp_valid,
   output gcns_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_data
);
   import gcns_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequence the item
   gcns_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // hold the store, distance unit and result register
   gcns_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* sv/gcns_chk.sv */
// ----------------------------------------------------------------------------
// gcns_chk
// Port level checks for the grid cell neighbor search block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gcns_chk (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input gcns_pkg::rsp_type rsp_data
);
   import gcns_pkg::*;

   `GCNS_ASSERT_NEXT(a_take_busy, clock, reset, start && !busy, busy && !rsp_valid, "item taken without busy")
   `GCNS_ASSERT_ALWAYS(a_none_last, clock, reset, !(rsp_valid && rsp_data.none_found) || rsp_data.is_last, "empty result not last")
   `GCNS_ASSERT_ALWAYS(a_ovf_list, clock, reset, !(rsp_valid && rsp_data.overflow) || !rsp_data.none_found, "overflow without neighbor")
   `GCNS_ASSERT_NEXT(a_more_busy, clock, reset, rsp_valid && !rsp_data.is_last, busy, "list ended early")

endmodule

bind grid_cell_neighbor_search gcns_chk u_gcns_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

/* tb/sv/tb_grid_cell_neighbor_search.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_cell_neighbor_search
// Self-checking bench for the grid cell neighbor search block.
// ----------------------------------------------------------------------------
// A table of directed items runs first, with the known answers typed in where
// they are obvious. A tight cluster that overflows a list and random clustered
// particle sets follow, checked against a neighbor predictor kept inside the
// bench. The cell size is rewritten only while the block is idle.
// ----------------------------------------------------------------------------
module tb_grid_cell_neighbor_search;
   import gcns_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 360;
   localparam int CYCLE_LIMIT  = 10000000;

   typedef struct {
      req_type r;
      bit      typed;
      rsp_type t;
   } row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [31:0] csr_data = '0;

   // typed answer travels with the item that is being offered
   logic    row_typed = 1'b0;
   rsp_type row_rsp   = '0;

   // shadow of the particle store
   int signed    shadow_pos [MAX_PARTICLES][3];
   longint       shadow_cell[MAX_PARTICLES][3];
   bit           shadow_bnd [MAX_PARTICLES];
   int unsigned  shadow_count = 0;
   int unsigned  shadow_cs    = CELL_SIZE_RESET;

   rsp_type      pending_rsp[$];
   rsp_type      fresh_rsp[$];
   int           errors = 0;
   int           cycles = 0;

   grid_cell_neighbor_search i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
   endtask

   function automatic rsp_type mk_rsp(input int idx, input bit none, input bit last,
                                      input bit ovf, input logic [1:0] st);
      rsp_type r;
      r.neighbor_index = IDX_W'(idx);
      r.none_found     = none;
      r.is_last        = last;
      r.overflow       = ovf;
      r.status         = st;
      return r;
   endfunction

   function automatic longint floor_cell(input int signed p, input longint d);
      longint n, q;
      n = p;
      q = n / d;
      if ((n % d) != 0 && n < 0) q -= 1;
      return q;
   endfunction

   function automatic logic [63:0] dist_sq(input int unsigned j, input int unsigned q);
      logic [64:0] acc;
      logic [63:0] m;
      longint      d;
      acc = '0;
      for (int a = 0; a < 3; a++) begin
         d = longint'(shadow_pos[j][a]) - longint'(shadow_pos[q][a]);
         m = (d < 0) ? -d : d;
         acc = acc[63:0] + m * m;
         if (acc[64]) acc = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
      end
      return acc[63:0];
   endfunction

   // Work out the results of one item into fresh_rsp and advance the shadow.
   function automatic void predict_item(input req_type r);
      longint      cs;
      logic [63:0] r2;
      int unsigned q;
      int          n;
      bit          ovf;
      int          hits[$];
      cs = (shadow_cs == 0) ? 1 : shadow_cs;
      fresh_rsp.delete();
      case (r.kind)
         KIND_LOAD: begin
            if (shadow_count >= MAX_PARTICLES) begin
               fresh_rsp.insert(fresh_rsp.size(), mk_rsp(0, 1, 1, 0, STATUS_FULL));
            end else begin
               shadow_pos[shadow_count][0] = r.pos_x;
               shadow_pos[shadow_count][1] = r.pos_y;
               shadow_pos[shadow_count][2] = r.pos_z;
               shadow_bnd[shadow_count]    = r.is_boundary;
               for (int a = 0; a < 3; a++)
                  shadow_cell[shadow_count][a] = floor_cell(shadow_pos[shadow_count][a], cs);
               fresh_rsp.insert(fresh_rsp.size(), mk_rsp(shadow_count, 1, 1, 0, STATUS_OK));
               shadow_count++;
            end
         end
         KIND_CLEAR: begin
            shadow_count = 0;
            fresh_rsp.insert(fresh_rsp.size(), mk_rsp(0, 1, 1, 0, STATUS_OK));
         end
         KIND_QUERY: begin
            q = r.query_index;
            r2 = cs * cs;
            if (q >= shadow_count) begin
               fresh_rsp.insert(fresh_rsp.size(), mk_rsp(0, 1, 1, 0, STATUS_NOT_LOADED));
            end else if (shadow_bnd[q]) begin
               fresh_rsp.insert(fresh_rsp.size(), mk_rsp(0, 1, 1, 0, STATUS_OK));
            end else begin
               ovf = 0;
               // walk dx, then dy, then dz, ascending index inside each cell
               for (int dx = -1; dx <= 1; dx++)
                  for (int dy = -1; dy <= 1; dy++)
                     for (int dz = -1; dz <= 1; dz++)
                        for (int unsigned j = 0; j < shadow_count; j++) begin
                           if (j == q) continue;
                           if (shadow_cell[j][0] != shadow_cell[q][0] + dx ||
                               shadow_cell[j][1] != shadow_cell[q][1] + dy ||
                               shadow_cell[j][2] != shadow_cell[q][2] + dz) continue;
                           if (dist_sq(j, q) > r2) continue;
                           if (hits.size() >= MAX_NEIGHBORS) ovf = 1;
                           else hits.insert(hits.size(), j);
                        end
               n = hits.size();
               if (n == 0) fresh_rsp.insert(fresh_rsp.size(), mk_rsp(0, 1, 1, 0, STATUS_OK));
               for (int k = 0; k < n; k++)
                  fresh_rsp.insert(fresh_rsp.size(),
                                   mk_rsp(hits[k], 0, k == n - 1, ovf, STATUS_OK));
            end
         end
         default: ;   // unused kind: no result, no change
      endcase
   endfunction

   // Predict on accepted items, check every result against the oldest one.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) shadow_cs = csr_data;
         if (start && !busy) begin
            predict_item(req_data);
            if (row_typed) pending_rsp.insert(pending_rsp.size(), row_rsp);
            else foreach (fresh_rsp[k]) pending_rsp.insert(pending_rsp.size(), fresh_rsp[k]);
         end
         if (rsp_valid) begin
            if (pending_rsp.size() == 0) begin
               report("unexpected result", rsp_data.neighbor_index, -1);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.neighbor_index !== want.neighbor_index)
                  report("neighbor_index", rsp_data.neighbor_index, want.neighbor_index);
               if (rsp_data.none_found !== want.none_found)
                  report("none_found", rsp_data.none_found, want.none_found);
               if (rsp_data.is_last !== want.is_last)
                  report("is_last", rsp_data.is_last, want.is_last);
               if (rsp_data.overflow !== want.overflow)
                  report("overflow", rsp_data.overflow, want.overflow);
               if (rsp_data.status !== want.status)
                  report("status", rsp_data.status, want.status);
            end
         end
      end
   end

   // Offer one item and hold it until the block takes it.
   task automatic send(input req_type r, input bit typed = 0, input rsp_type t = '0);
      start     <= 1'b1;
      req_data  <= r;
      row_typed <= typed;
      row_rsp   <= t;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic hold_off(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Drain, let a result-less item settle, then write the cell size.
   task automatic write_cell_size(input logic [31:0] v);
      start <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0 || busy !== 1'b0);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type noise_req(input logic [1:0] kind);
      req_type r;
      r.kind        = kind;
      r.pos_x       = $urandom;
      r.pos_y       = $urandom;
      r.pos_z       = $urandom;
      r.is_boundary = 1'($urandom);
      r.query_index = IDX_W'($urandom);
      return r;
   endfunction

   function automatic req_type load_req(input int x, input int y, input int z, input bit b);
      req_type r;
      r = noise_req(KIND_LOAD);
      r.pos_x = x;
      r.pos_y = y;
      r.pos_z = z;
      r.is_boundary = b;
      return r;
   endfunction

   function automatic req_type query_req(input int idx);
      req_type r;
      r = noise_req(KIND_QUERY);
      r.query_index = IDX_W'(idx);
      return r;
   endfunction

   // random offset in [-span, span]
   function automatic int jitter(input longint span);
      longint unsigned u;
      u = {$urandom, $urandom};
      return int'(longint'(u % longint'(2 * span + 1)) - span);
   endfunction

   // sender idle share in percent for each quarter of the random part
   function automatic int gap_for(input int sent);
      int pct;
      case ((sent * 4) / RANDOM_ITEMS)
         1:       pct = 79;
         3:       pct = 10;
         default: pct = 0;
      endcase
      return ($urandom_range(0, 99) < pct) ? $urandom_range(1, 6) : 0;
   endfunction

   initial begin
      row_type     rows[$];
      int          sent;
      int          seq_no;
      int          n_load;
      int          n_query;
      int unsigned cs;
      longint      span;
      int          cx, cy, cz;
      bit          tight;
      int          pick;
      logic [31:0] cs_pick[4];

      cs_pick = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd65536};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; typed answers where they are obvious.
      rows.insert(rows.size(), '{query_req(0), 1, mk_rsp(0, 1, 1, 0, STATUS_NOT_LOADED)});
      rows.insert(rows.size(), '{noise_req(KIND_CLEAR), 1, mk_rsp(0, 1, 1, 0, STATUS_OK)});
      rows.insert(rows.size(), '{load_req(0, 0, 0, 0), 1, mk_rsp(0, 1, 1, 0, STATUS_OK)});
      rows.insert(rows.size(), '{query_req(0), 1, mk_rsp(0, 1, 1, 0, STATUS_OK)});
      rows.insert(rows.size(), '{load_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1), 1,
                                 mk_rsp(1, 1, 1, 0, STATUS_OK)});
      rows.insert(rows.size(), '{query_req(1), 1, mk_rsp(0, 1, 1, 0, STATUS_OK)});
      rows.insert(rows.size(), '{load_req(32'h8000, 32'h8000, 0, 0), 1,
                                 mk_rsp(2, 1, 1, 0, STATUS_OK)});
      // exactly one cell size away: on the radius and in the next cell
      rows.insert(rows.size(), '{load_req(32'h10000, 0, 0, 0), 1,
                                 mk_rsp(3, 1, 1, 0, STATUS_OK)});
      // just below zero lands in cell -1
      rows.insert(rows.size(), '{load_req(-1, -1, -1, 0), 1, mk_rsp(4, 1, 1, 0, STATUS_OK)});
      rows.insert(rows.size(), '{query_req(0), 0, '0});
      rows.insert(rows.size(), '{query_req(2), 0, '0});
      rows.insert(rows.size(), '{query_req(4), 0, '0});
      rows.insert(rows.size(), '{query_req(5), 1, mk_rsp(0, 1, 1, 0, STATUS_NOT_LOADED)});
      rows.insert(rows.size(), '{query_req(1023), 1, mk_rsp(0, 1, 1, 0, STATUS_NOT_LOADED)});
      rows.insert(rows.size(), '{noise_req(KIND_UNUSED), 0, '0});
      rows.insert(rows.size(), '{load_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0), 1,
                                 mk_rsp(5, 1, 1, 0, STATUS_OK)});
      rows.insert(rows.size(), '{load_req(32'h8000_FFFF, 32'h8000_8000, 32'h8001_0000, 0), 1,
                                 mk_rsp(6, 1, 1, 0, STATUS_OK)});
      rows.insert(rows.size(), '{query_req(5), 0, '0});
      rows.insert(rows.size(), '{query_req(6), 0, '0});
      rows.insert(rows.size(), '{noise_req(KIND_CLEAR), 1, mk_rsp(0, 1, 1, 0, STATUS_OK)});
      rows.insert(rows.size(), '{query_req(0), 1, mk_rsp(0, 1, 1, 0, STATUS_NOT_LOADED)});
      foreach (rows[i]) send(rows[i].r, rows[i].typed, rows[i].t);

      // A tight cluster on one point forces an overflowed list.
      cx = $urandom;
      for (int i = 0; i < 70; i++) send(load_req(cx, cx, cx, 0));
      send(query_req(3));
      send(query_req(69));
      send(query_req($urandom_range(0, 1023)));
      hold_off(1);

      // Random particle sets, mostly clustered so the queries find neighbors.
      sent = 0;
      seq_no = 0;
      cs = CELL_SIZE_RESET;
      while (sent < RANDOM_ITEMS) begin
         if (seq_no < 4 || $urandom_range(0, 2) == 0) begin
            pick = $urandom_range(0, 3);
            cs = (seq_no < 4) ? cs_pick[seq_no] :
                 (pick == 0) ? $urandom :
                 (pick == 1) ? $urandom_range(1, 32'h40000) : cs_pick[$urandom_range(0, 3)];
            write_cell_size(cs);
         end
         send(noise_req(KIND_CLEAR));
         hold_off(gap_for(sent));
         sent++;
         tight  = ($urandom_range(0, 9) == 0);
         n_load = tight ? $urandom_range(66, 72) : $urandom_range(1, 12);
         span   = (cs == 0) ? 1 : cs;
         span   = tight ? span / 4 : 2 * span;
         cx = $urandom;
         cy = $urandom;
         cz = $urandom;
         for (int i = 0; i < n_load; i++) begin
            if ($urandom_range(0, 7) == 0)
               send(load_req($urandom, $urandom, $urandom, $urandom_range(0, 3) == 0));
            else
               send(load_req(cx + jitter(span), cy + jitter(span), cz + jitter(span),
                             $urandom_range(0, 3) == 0));
            hold_off(gap_for(sent));
            sent++;
         end
         // cells stay as loaded, only the radius follows the new size
         if ($urandom_range(0, 3) == 0) begin
            cs = $urandom_range(0, 1) ? $urandom : $urandom_range(1, 32'h30000);
            write_cell_size(cs);
         end
         n_query = $urandom_range(2, 6);
         for (int i = 0; i < n_query; i++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               send(noise_req(KIND_UNUSED));
            end else begin
               send(query_req((pick == 1) ? $urandom_range(0, 1023)
                                          : $urandom_range(0, n_load - 1)));
               sent++;
            end
            hold_off(gap_for(sent));
         end
         seq_no++;
      end
      hold_off(1);

      // Drain what is still owed, then let the block settle.
      while (pending_rsp.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/gcns_pkg.sv
sv/gcns_div.sv
sv/gcns_dp.sv
sv/gcns_ctrl.sv
sv/grid_cell_neighbor_search.sv
sv/gcns_chk.sv
tb/sv/tb_grid_cell_neighbor_search.sv
